@@ src/prpi_pkg.sv @@
// ----------------------------------------------------------------------------
// PageRank power iteration package
// Shared constants, port widths, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package prpi_pkg;

  // Default sizing of the block.
  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 16384;
  localparam int RANK_BITS_DEF = 32;

  // Fixed port widths.
  localparam int ACTION_W   = 2;
  localparam int NODE_IDX_W = 10;
  localparam int STATUS_W   = 2;
  localparam int RANK_OUT_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register widths and reset values.
  localparam int NODE_COUNT_W = 11;
  localparam int DAMPING_W    = 16;
  localparam int ITER_W       = 8;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;
  localparam logic [DAMPING_W-1:0]    DAMPING_RST    = 16'd55706;
  localparam logic [ITER_W-1:0]       ITER_RST       = 8'd75;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_DAMPING    = 2'd1,
    CFG_ITERATIONS = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_WR,
    S_READ,
    S_INIT_DIV,
    S_TEL_DIV,
    S_INIT_WR,
    S_N1_RD,
    S_N1_CHK,
    S_N1_DIV,
    S_DANG_START,
    S_DANG_DIV,
    S_E_RD,
    S_E_CHK,
    S_E_ACC,
    S_N2_RD,
    S_N2_MUL,
    S_N2_WR
  } state_t;

endpackage

@@ src/prpi_ram.sv @@
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module prpi_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/prpi_div.sv @@
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses at the end.
// ----------------------------------------------------------------------------
module prpi_div #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // Shift in the next dividend bit and try a subtraction.
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      count <= CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

@@ src/pagerank_power_iteration.sv @@
// One item is in work at a time. After reset a clearing pass over every node entry
// zeroes degrees and ranks before the first item is taken.
// ----------------------------------------------------------------------------
// PageRank power iteration
// Edge store with out-degree counts, and a sequencer that runs fixed-point
// power iterations over it using one shared iterative divider.
// ----------------------------------------------------------------------------
module pagerank_power_iteration #(
  parameter int MAX_NODES = prpi_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = prpi_pkg::MAX_EDGES_DEF,
  parameter int RANK_BITS = prpi_pkg::RANK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [prpi_pkg::ACTION_W-1:0]   action,
  input  logic [prpi_pkg::NODE_IDX_W-1:0] source_node,
  input  logic [prpi_pkg::NODE_IDX_W-1:0] target_node,
  input  logic [prpi_pkg::NODE_IDX_W-1:0] query_node,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [prpi_pkg::STATUS_W-1:0]   status,
  output logic [prpi_pkg::RANK_OUT_W-1:0] rank_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prpi_pkg::CFG_DATA_W-1:0] cfg_data
);

  import prpi_pkg::*;

  localparam int RB     = RANK_BITS;
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W   = $clog2(MAX_EDGES + 1);
  localparam int DIV_W  = (EC_W > CNT_W) ? EC_W : CNT_W;
  localparam int PROD_W = RB + DAMPING_W;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);
  localparam logic [RB-1:0]     RANK_ONE  = RB'(1) << (RB - 1);

  function automatic logic [RB-1:0] sat_add(input logic [RB-1:0] a, input logic [RB-1:0] b);
    logic [RB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RB] ? {RB{1'b1}} : s[RB-1:0];
  endfunction

  // Configuration registers.
  logic [NODE_COUNT_W-1:0] node_count;
  logic [DAMPING_W-1:0]    damping_factor;
  logic [ITER_W-1:0]       iteration_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      damping_factor <= DAMPING_RST;
      iteration_count <= ITER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_NODE_COUNT: node_count <= cfg_data[NODE_COUNT_W-1:0];
        CFG_DAMPING:    damping_factor <= cfg_data[DAMPING_W-1:0];
        CFG_ITERATIONS: iteration_count <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Node count in use, clamped to 1..MAX_NODES.
  logic [31:0]      nc_wide;
  logic [CNT_W-1:0] n_cur;

  always_comb begin
    nc_wide = 32'(node_count);
    if (nc_wide == 32'd0) begin
      n_cur = CNT_W'(1);
    end else if (nc_wide > 32'(MAX_NODES)) begin
      n_cur = CNT_W'(MAX_NODES);
    end else begin
      n_cur = CNT_W'(nc_wide);
    end
  end

  // Sequencer and datapath registers.
  state_t           state, state_next;
  logic [NODE_W-1:0] node_idx, node_idx_next;
  logic [EA_W-1:0]  edge_idx, edge_idx_next;
  logic [EC_W-1:0]  edge_total, edge_total_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic [ITER_W-1:0] iter_total, iter_total_next;
  logic             clr_rank, clr_rank_next;
  logic             clr_post, clr_post_next;
  logic [CNT_W-1:0] n_run, n_run_next;
  logic [DAMPING_W-1:0] d_run, d_run_next;
  logic [RB-1:0]    init_val, init_val_next;
  logic [RB-1:0]    teleport, teleport_next;
  logic [RB-1:0]    dang, dang_next;
  logic [RB-1:0]    dshare, dshare_next;
  logic [PROD_W-1:0] prod, prod_next;
  logic [NODE_W-1:0] src_reg, src_reg_next;
  logic [NODE_W-1:0] tgt_reg, tgt_reg_next;

  // Output register.
  logic                  out_valid_next;
  status_t               status_reg, status_next;
  logic [RANK_OUT_W-1:0] rank_reg, rank_next_val;
  logic                  post;
  status_t               post_status;
  logic [RANK_OUT_W-1:0] post_value;

  // Memory ports.
  logic              deg_we, rc_we, rn_we, sh_we, edge_we;
  logic [NODE_W-1:0] deg_waddr, deg_raddr, rc_waddr, rc_raddr;
  logic [NODE_W-1:0] rn_waddr, rn_raddr, sh_waddr, sh_raddr;
  logic [EC_W-1:0]   deg_wdata, deg_rdata;
  logic [RB-1:0]     rc_wdata, rc_rdata, rn_wdata, rn_rdata, sh_wdata, sh_rdata;
  logic [EA_W-1:0]   edge_waddr, edge_raddr;
  logic [2*NODE_W-1:0] edge_wdata, edge_rdata;

  // Divider port.
  logic             div_start, div_done;
  logic [RB-1:0]    div_dividend, div_q;
  logic [DIV_W-1:0] div_divisor;

  // Helpers.
  logic              accept;
  logic [RB+15:0]    tel_wide;
  logic [RB-1:0]     tel_num;
  logic [NODE_W-1:0] e_src, e_tgt;
  logic              last_run_node;
  logic              last_edge;
  logic [RB-1:0]     n2_sum;

  assign in_stall = !((state == S_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  assign tel_wide = (RB + 16)'(17'h10000 - {1'b0, d_run}) << (RB - 1);
  assign tel_num  = tel_wide[RB+15:16];
  assign e_src    = edge_rdata[2*NODE_W-1:NODE_W];
  assign e_tgt    = edge_rdata[NODE_W-1:0];
  assign last_run_node = (CNT_W'(node_idx) == (n_run - CNT_W'(1)));
  assign last_edge = ((EC_W'(edge_idx) + EC_W'(1)) == edge_total);
  assign n2_sum   = sat_add(rn_rdata, dshare);

  // Next-state and control logic.
  always_comb begin
    state_next = state;
    node_idx_next = node_idx;
    edge_idx_next = edge_idx;
    edge_total_next = edge_total;
    iter_next = iter;
    iter_total_next = iter_total;
    clr_rank_next = clr_rank;
    clr_post_next = clr_post;
    n_run_next = n_run;
    d_run_next = d_run;
    init_val_next = init_val;
    teleport_next = teleport;
    dang_next = dang;
    dshare_next = dshare;
    prod_next = prod;
    src_reg_next = src_reg;
    tgt_reg_next = tgt_reg;
    post = 1'b0;
    post_status = ST_OK;
    post_value = '0;
    deg_we = 1'b0;
    deg_waddr = node_idx;
    deg_wdata = '0;
    deg_raddr = node_idx;
    rc_we = 1'b0;
    rc_waddr = node_idx;
    rc_wdata = '0;
    rc_raddr = node_idx;
    rn_we = 1'b0;
    rn_waddr = node_idx;
    rn_wdata = '0;
    rn_raddr = node_idx;
    sh_we = 1'b0;
    sh_waddr = node_idx;
    sh_wdata = '0;
    sh_raddr = node_idx;
    edge_we = 1'b0;
    edge_waddr = edge_total[EA_W-1:0];
    edge_wdata = '0;
    edge_raddr = edge_idx;
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor = '0;

    case (state)
      // Sweep every node entry: degrees always, ranks after reset.
      S_CLEAR: begin
        deg_we = 1'b1;
        rc_we = clr_rank;
        if (node_idx == LAST_NODE) begin
          node_idx_next = '0;
          clr_rank_next = 1'b0;
          clr_post_next = 1'b0;
          post = clr_post;
          state_next = S_IDLE;
        end else begin
          node_idx_next = node_idx + 1'b1;
        end
      end

      // Take one item and decode it.
      S_IDLE: begin
        if (accept) begin
          case (action_t'(action))
            ACT_ADD: begin
              if ((32'(source_node) >= 32'(n_cur)) || (32'(target_node) >= 32'(n_cur))) begin
                post = 1'b1;
                post_status = ST_RANGE;
              end else if (edge_total == EC_W'(MAX_EDGES)) begin
                post = 1'b1;
                post_status = ST_FULL;
              end else begin
                edge_we = 1'b1;
                edge_wdata = {NODE_W'(source_node), NODE_W'(target_node)};
                deg_raddr = NODE_W'(source_node);
                src_reg_next = NODE_W'(source_node);
                state_next = S_ADD_WR;
              end
            end
            ACT_RUN: begin
              n_run_next = n_cur;
              d_run_next = damping_factor;
              iter_total_next = iteration_count;
              div_start = 1'b1;
              div_dividend = RANK_ONE;
              div_divisor = DIV_W'(n_cur);
              state_next = S_INIT_DIV;
            end
            ACT_READ: begin
              if (32'(query_node) >= 32'(n_cur)) begin
                post = 1'b1;
                post_status = ST_RANGE;
              end else begin
                rc_raddr = NODE_W'(query_node);
                state_next = S_READ;
              end
            end
            ACT_CLEAR: begin
              edge_total_next = '0;
              node_idx_next = '0;
              clr_rank_next = 1'b0;
              clr_post_next = 1'b1;
              state_next = S_CLEAR;
            end
            default: ;
          endcase
        end
      end

      // Count the new edge toward the origin's out-degree.
      S_ADD_WR: begin
        deg_we = 1'b1;
        deg_waddr = src_reg;
        deg_wdata = deg_rdata + EC_W'(1);
        edge_total_next = edge_total + EC_W'(1);
        post = 1'b1;
        state_next = S_IDLE;
      end

      S_READ: begin
        post = 1'b1;
        post_value = RANK_OUT_W'(rc_rdata);
        state_next = S_IDLE;
      end

      // Initial rank 1/n, then the teleport term.
      S_INIT_DIV: begin
        if (div_done) begin
          init_val_next = div_q;
          div_start = 1'b1;
          div_dividend = tel_num;
          div_divisor = DIV_W'(n_run);
          state_next = S_TEL_DIV;
        end
      end

      S_TEL_DIV: begin
        if (div_done) begin
          teleport_next = div_q;
          node_idx_next = '0;
          state_next = S_INIT_WR;
        end
      end

      S_INIT_WR: begin
        rc_we = 1'b1;
        rc_wdata = (CNT_W'(node_idx) < n_run) ? init_val : '0;
        if (node_idx == LAST_NODE) begin
          node_idx_next = '0;
          iter_next = '0;
          dang_next = '0;
          if (iter_total == '0) begin
            post = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_N1_RD;
          end
        end else begin
          node_idx_next = node_idx + 1'b1;
        end
      end

      // Per node: zero the accumulator, pool dangling rank or compute the share.
      S_N1_RD: begin
        rn_we = 1'b1;
        state_next = S_N1_CHK;
      end

      S_N1_CHK: begin
        if (deg_rdata == '0) begin
          dang_next = sat_add(dang, rc_rdata);
          sh_we = 1'b1;
          if (last_run_node) begin
            node_idx_next = '0;
            state_next = S_DANG_START;
          end else begin
            node_idx_next = node_idx + 1'b1;
            state_next = S_N1_RD;
          end
        end else begin
          div_start = 1'b1;
          div_dividend = rc_rdata;
          div_divisor = DIV_W'(deg_rdata);
          state_next = S_N1_DIV;
        end
      end

      S_N1_DIV: begin
        if (div_done) begin
          sh_we = 1'b1;
          sh_wdata = div_q;
          if (last_run_node) begin
            node_idx_next = '0;
            state_next = S_DANG_START;
          end else begin
            node_idx_next = node_idx + 1'b1;
            state_next = S_N1_RD;
          end
        end
      end

      // Spread the dangling pool evenly.
      S_DANG_START: begin
        div_start = 1'b1;
        div_dividend = dang;
        div_divisor = DIV_W'(n_run);
        state_next = S_DANG_DIV;
      end

      S_DANG_DIV: begin
        if (div_done) begin
          dshare_next = div_q;
          edge_idx_next = '0;
          node_idx_next = '0;
          state_next = (edge_total == '0) ? S_N2_RD : S_E_RD;
        end
      end

      // Per edge: add the origin's share into the target's accumulator.
      S_E_RD: begin
        state_next = S_E_CHK;
      end

      S_E_CHK: begin
        if ((CNT_W'(e_src) >= n_run) || (CNT_W'(e_tgt) >= n_run)) begin
          if (last_edge) begin
            node_idx_next = '0;
            state_next = S_N2_RD;
          end else begin
            edge_idx_next = edge_idx + 1'b1;
            state_next = S_E_RD;
          end
        end else begin
          sh_raddr = e_src;
          rn_raddr = e_tgt;
          tgt_reg_next = e_tgt;
          state_next = S_E_ACC;
        end
      end

      S_E_ACC: begin
        rn_we = 1'b1;
        rn_waddr = tgt_reg;
        rn_wdata = sat_add(rn_rdata, sh_rdata);
        if (last_edge) begin
          node_idx_next = '0;
          state_next = S_N2_RD;
        end else begin
          edge_idx_next = edge_idx + 1'b1;
          state_next = S_E_RD;
        end
      end

      // Per node: add the dangling share, damp, add teleport, store the new rank.
      S_N2_RD: begin
        state_next = S_N2_MUL;
      end

      S_N2_MUL: begin
        prod_next = PROD_W'(n2_sum) * PROD_W'(d_run);
        state_next = S_N2_WR;
      end

      S_N2_WR: begin
        rc_we = 1'b1;
        rc_wdata = sat_add(prod[PROD_W-1:DAMPING_W], teleport);
        if (last_run_node) begin
          node_idx_next = '0;
          if ((iter + 1'b1) == iter_total) begin
            post = 1'b1;
            state_next = S_IDLE;
          end else begin
            iter_next = iter + 1'b1;
            dang_next = '0;
            state_next = S_N1_RD;
          end
        end else begin
          node_idx_next = node_idx + 1'b1;
          state_next = S_N2_RD;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Result register: load a new result, or hold until it is transferred.
    out_valid_next = post ? 1'b1 : (out_valid && out_stall);
    status_next = post ? post_status : status_reg;
    rank_next_val = post ? post_value : rank_reg;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      node_idx <= '0;
      edge_total <= '0;
      clr_rank <= 1'b1;
      clr_post <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      node_idx <= node_idx_next;
      edge_total <= edge_total_next;
      clr_rank <= clr_rank_next;
      clr_post <= clr_post_next;
      out_valid <= out_valid_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    edge_idx <= edge_idx_next;
    iter <= iter_next;
    iter_total <= iter_total_next;
    n_run <= n_run_next;
    d_run <= d_run_next;
    init_val <= init_val_next;
    teleport <= teleport_next;
    dang <= dang_next;
    dshare <= dshare_next;
    prod <= prod_next;
    src_reg <= src_reg_next;
    tgt_reg <= tgt_reg_next;
    status_reg <= status_next;
    rank_reg <= rank_next_val;
  end

  assign status = status_reg;
  assign rank_value = rank_reg;

  // Storage.
  prpi_ram #(.DEPTH(MAX_EDGES), .WIDTH(2 * NODE_W), .AW(EA_W)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  prpi_ram #(.DEPTH(MAX_NODES), .WIDTH(EC_W), .AW(NODE_W)) u_deg_ram (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );

  prpi_ram #(.DEPTH(MAX_NODES), .WIDTH(RB), .AW(NODE_W)) u_rank_ram (
    .clk(clk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
    .raddr(rc_raddr), .rdata(rc_rdata)
  );

  prpi_ram #(.DEPTH(MAX_NODES), .WIDTH(RB), .AW(NODE_W)) u_acc_ram (
    .clk(clk), .we(rn_we), .waddr(rn_waddr), .wdata(rn_wdata),
    .raddr(rn_raddr), .rdata(rn_rdata)
  );

  prpi_ram #(.DEPTH(MAX_NODES), .WIDTH(RB), .AW(NODE_W)) u_share_ram (
    .clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
    .raddr(sh_raddr), .rdata(sh_rdata)
  );

  // Shared divider.
  prpi_div #(.DIVIDEND_W(RB), .DIVISOR_W(DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

endmodule
